[rtl/link_message_framer_rings_top_defines.svh]
// Assertion macros used by the link message framer RTL.
`ifndef LINK_MESSAGE_FRAMER_RINGS_TOP_DEFINES_SVH
`define LINK_MESSAGE_FRAMER_RINGS_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LMFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LMFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lmfr_pkg.sv]
package lmfr_pkg;

  // Link halfword width and operation code width.
  localparam int HALF_W = 16;
  localparam int MODE_W = 2;

  // Operation codes carried on in_mode.
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUEUE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POLL  = 2'd2;

endpackage

[rtl/link_message_framer_rings_top.sv]
// Serial link message framer with a transmit ring and a receive ring.
// Input channel: an operation word (in_mode, in_link_error, in_rx_word,
// in_send_message) is taken at a rising edge where start is high and busy is low.
// Mode tick without a link error files the received halfword into the message
// being assembled and drives the next transmit halfword; mode queue stores a
// message in the transmit ring; mode poll returns the next receive ring message.
// Result channel: exactly one result word per operation, shown for one cycle
// while out_valid is high. The receiver cannot stall, so no result is held back.
// Sequencing: one operation is in flight at a time and passes through the idle
// state (accept), the exec state (ring scan with memory access) and the fetch
// state (memory read data capture); the result registers are loaded at the end of
// fetch. The next start may be taken in the cycle the result is shown.
// Both rings live in synchronous memories with registered read data; their
// occupied bits are flip-flops, and a ring scan is a rotated priority encoder
// over those bits. Entries are read only while occupied.
// Reset (rst_n low, synchronous) empties both rings, clears the slot pointers
// and framing counters, and drops any pending result. No clearing pass is needed.
module link_message_framer_rings_top #(
  parameter int TX_DEPTH          = 8,
  parameter int RX_DEPTH          = 64,
  parameter int WORDS_PER_MESSAGE = 3
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         start,
  output logic                                         busy,
  input  logic [lmfr_pkg::MODE_W-1:0]                  in_mode,
  input  logic                                         in_link_error,
  input  logic [lmfr_pkg::HALF_W-1:0]                  in_rx_word,
  input  logic [lmfr_pkg::HALF_W*WORDS_PER_MESSAGE-1:0] in_send_message,
  output logic                                         out_valid,
  output logic [lmfr_pkg::HALF_W-1:0]                  out_tx_word,
  output logic                                         out_tx_drive,
  output logic                                         out_msg_valid,
  output logic [lmfr_pkg::HALF_W*WORDS_PER_MESSAGE-1:0] out_msg_data,
  output logic                                         out_dropped
);

  import lmfr_pkg::*;

  `include "link_message_framer_rings_top_defines.svh"

  localparam int MSG_W = HALF_W * WORDS_PER_MESSAGE;
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int CNT_W = $clog2(WORDS_PER_MESSAGE + 1);

  localparam logic [CNT_W-1:0] WPM     = CNT_W'(WORDS_PER_MESSAGE);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;

  // Ring memories and their registered read data.
  logic [MSG_W-1:0] tx_mem [TX_DEPTH];
  logic [MSG_W-1:0] rx_mem [RX_DEPTH];
  logic [MSG_W-1:0] tx_rd_r;
  logic [MSG_W-1:0] rx_rd_r;

  logic             tx_we, tx_re, rx_we, rx_re;
  logic [TX_AW-1:0] tx_wa, tx_ra;
  logic [RX_AW-1:0] rx_wa, rx_ra;
  logic [MSG_W-1:0] tx_wd, rx_wd;

  // Control state.
  logic [1:0]          state_r, state_nxt;
  logic [TX_DEPTH-1:0] tx_occ_r, tx_occ_nxt;
  logic [RX_DEPTH-1:0] rx_occ_r, rx_occ_nxt;
  logic [TX_AW-1:0]    tx_wr_slot_r, tx_wr_slot_nxt;
  logic [TX_AW-1:0]    tx_rd_slot_r, tx_rd_slot_nxt;
  logic [RX_AW-1:0]    rx_wr_slot_r, rx_wr_slot_nxt;
  logic [RX_AW-1:0]    rx_rd_slot_r, rx_rd_slot_nxt;
  logic [CNT_W-1:0]    rx_cnt_r, rx_cnt_nxt;
  logic [CNT_W-1:0]    tx_cnt_r, tx_cnt_nxt;
  logic                rx_held_r, rx_held_nxt;
  logic                rx_zero_r, rx_zero_nxt;
  logic                tx_held_r, tx_held_nxt;
  logic [MSG_W-1:0]    rx_asm_r, rx_asm_nxt;
  logic [MSG_W-1:0]    tx_cur_r, tx_cur_nxt;

  // Per-operation flags passed from the scan cycle to the capture cycle.
  logic drop_r, drop_nxt;
  logic drive_r, drive_nxt;
  logic load_r, load_nxt;
  logic hit_r, hit_nxt;

  // Captured operation word.
  logic [MODE_W-1:0] op_mode_r;
  logic              op_err_r;
  logic [HALF_W-1:0] op_rx_word_r;
  logic [MSG_W-1:0]  op_msg_r;

  // Result registers.
  logic              out_valid_r, out_valid_nxt;
  logic [HALF_W-1:0] out_tx_word_r, out_tx_word_nxt;
  logic              out_tx_drive_r, out_tx_drive_nxt;
  logic              out_msg_valid_r, out_msg_valid_nxt;
  logic [MSG_W-1:0]  out_msg_data_r, out_msg_data_nxt;
  logic              out_dropped_r, out_dropped_nxt;

  // Scan results.
  logic [TX_DEPTH-1:0] tx_hi;
  logic [RX_DEPTH-1:0] rx_hi;
  logic [TX_AW-1:0]    tx_sel;
  logic [RX_AW-1:0]    rx_sel;
  logic                tx_hit, rx_hit;

  // Work variables of the operation logic.
  logic             rx_bnd;
  logic [CNT_W-1:0] rx_base_cnt;
  logic [MSG_W-1:0] cur_sel;

  logic accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Rotated priority encoders: first occupied entry at or after the read slot,
  // wrapping to the lowest occupied entry.
  always_comb begin
    tx_hi  = '0;
    tx_sel = '0;
    for (int i = 0; i < TX_DEPTH; i++) begin
      tx_hi[i] = tx_occ_r[i] && (TX_AW'(i) >= tx_rd_slot_r);
    end
    for (int i = TX_DEPTH - 1; i >= 0; i--) begin
      if (tx_occ_r[i]) tx_sel = TX_AW'(i);
    end
    for (int i = TX_DEPTH - 1; i >= 0; i--) begin
      if (tx_hi[i]) tx_sel = TX_AW'(i);
    end
    tx_hit = |tx_occ_r;
  end

  always_comb begin
    rx_hi  = '0;
    rx_sel = '0;
    for (int i = 0; i < RX_DEPTH; i++) begin
      rx_hi[i] = rx_occ_r[i] && (RX_AW'(i) >= rx_rd_slot_r);
    end
    for (int i = RX_DEPTH - 1; i >= 0; i--) begin
      if (rx_occ_r[i]) rx_sel = RX_AW'(i);
    end
    for (int i = RX_DEPTH - 1; i >= 0; i--) begin
      if (rx_hi[i]) rx_sel = RX_AW'(i);
    end
    rx_hit = |rx_occ_r;
  end

  // Operation sequencer: scan and access the rings, then capture read data.
  always_comb begin
    state_nxt      = state_r;
    tx_occ_nxt     = tx_occ_r;
    rx_occ_nxt     = rx_occ_r;
    tx_wr_slot_nxt = tx_wr_slot_r;
    tx_rd_slot_nxt = tx_rd_slot_r;
    rx_wr_slot_nxt = rx_wr_slot_r;
    rx_rd_slot_nxt = rx_rd_slot_r;
    rx_cnt_nxt     = rx_cnt_r;
    tx_cnt_nxt     = tx_cnt_r;
    rx_held_nxt    = rx_held_r;
    rx_zero_nxt    = rx_zero_r;
    tx_held_nxt    = tx_held_r;
    rx_asm_nxt     = rx_asm_r;
    tx_cur_nxt     = tx_cur_r;
    drop_nxt       = drop_r;
    drive_nxt      = drive_r;
    load_nxt       = load_r;
    hit_nxt        = hit_r;

    tx_we = 1'b0;
    tx_re = 1'b0;
    rx_we = 1'b0;
    rx_re = 1'b0;
    tx_wa = tx_wr_slot_r;
    tx_ra = tx_sel;
    rx_wa = rx_wr_slot_r;
    rx_ra = rx_sel;
    tx_wd = op_msg_r;
    rx_wd = rx_asm_r;

    rx_bnd      = 1'b0;
    rx_base_cnt = rx_cnt_r;
    cur_sel     = load_r ? tx_rd_r : tx_cur_r;

    out_valid_nxt     = 1'b0;
    out_tx_word_nxt   = out_tx_word_r;
    out_tx_drive_nxt  = out_tx_drive_r;
    out_msg_valid_nxt = out_msg_valid_r;
    out_msg_data_nxt  = out_msg_data_r;
    out_dropped_nxt   = out_dropped_r;

    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end

      S_EXEC: begin
        drop_nxt  = 1'b0;
        drive_nxt = 1'b0;
        load_nxt  = 1'b0;
        hit_nxt   = 1'b0;
        state_nxt = S_FETCH;
        case (op_mode_r)
          MODE_TICK: begin
            if (!op_err_r) begin
              // Receive side: close a finished frame, then file the halfword.
              rx_bnd = (rx_cnt_r >= WPM);
              if (rx_bnd) begin
                if (rx_held_r && !rx_zero_r) begin
                  rx_we                  = 1'b1;
                  drop_nxt               = rx_occ_r[rx_wr_slot_r];
                  rx_occ_nxt[rx_wr_slot_r] = 1'b1;
                  rx_wr_slot_nxt = (rx_wr_slot_r == RX_LAST) ? '0 : rx_wr_slot_r + 1'b1;
                end
                rx_zero_nxt = 1'b1;
                rx_held_nxt = 1'b1;
                rx_asm_nxt  = '0;
                rx_base_cnt = '0;
              end
              if (rx_held_nxt) begin
                if (op_rx_word_r != '0) rx_zero_nxt = 1'b0;
                for (int i = 0; i < WORDS_PER_MESSAGE; i++) begin
                  if (rx_base_cnt == CNT_W'(i)) begin
                    rx_asm_nxt[i*HALF_W +: HALF_W] =
                      rx_asm_nxt[i*HALF_W +: HALF_W] | op_rx_word_r;
                  end
                end
              end
              rx_cnt_nxt = rx_base_cnt + 1'b1;

              // Transmit side: at a frame boundary take the next queued message.
              if (tx_cnt_r >= WPM) begin
                tx_cnt_nxt = '0;
                if (tx_hit) begin
                  tx_re              = 1'b1;
                  tx_occ_nxt[tx_sel] = 1'b0;
                  tx_rd_slot_nxt     = tx_sel;
                  tx_held_nxt        = 1'b1;
                  load_nxt           = 1'b1;
                end else begin
                  tx_rd_slot_nxt = (tx_rd_slot_r == TX_LAST) ? '0 : tx_rd_slot_r + 1'b1;
                  tx_held_nxt    = 1'b0;
                  tx_cur_nxt     = '0;
                end
              end
              drive_nxt = 1'b1;
            end
          end

          MODE_QUEUE: begin
            tx_we                    = 1'b1;
            drop_nxt                 = tx_occ_r[tx_wr_slot_r];
            tx_occ_nxt[tx_wr_slot_r] = 1'b1;
            tx_wr_slot_nxt = (tx_wr_slot_r == TX_LAST) ? '0 : tx_wr_slot_r + 1'b1;
          end

          MODE_POLL: begin
            // No message is given while a frame boundary is pending.
            if (rx_cnt_r < WPM) begin
              if (rx_hit) begin
                rx_re              = 1'b1;
                rx_occ_nxt[rx_sel] = 1'b0;
                rx_rd_slot_nxt     = rx_sel;
                hit_nxt            = 1'b1;
              end else begin
                rx_rd_slot_nxt = (rx_rd_slot_r == RX_LAST) ? '0 : rx_rd_slot_r + 1'b1;
              end
            end
          end

          default: begin
          end
        endcase
      end

      S_FETCH: begin
        // Capture read data and build the result word.
        state_nxt       = S_IDLE;
        tx_cur_nxt      = cur_sel;
        out_tx_word_nxt = '0;
        if (drive_r) begin
          if (tx_held_r) begin
            for (int i = 0; i < WORDS_PER_MESSAGE; i++) begin
              if (tx_cnt_r == CNT_W'(i)) out_tx_word_nxt = cur_sel[i*HALF_W +: HALF_W];
            end
          end
          tx_cnt_nxt = tx_cnt_r + 1'b1;
        end
        out_valid_nxt     = 1'b1;
        out_tx_drive_nxt  = drive_r;
        out_msg_valid_nxt = hit_r;
        out_msg_data_nxt  = hit_r ? rx_rd_r : '0;
        out_dropped_nxt   = drop_r;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Transmit ring memory.
  always_ff @(posedge clk) begin
    if (tx_we) tx_mem[tx_wa] <= tx_wd;
    if (tx_re) tx_rd_r <= tx_mem[tx_ra];
  end

  // Receive ring memory.
  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[rx_wa] <= rx_wd;
    if (rx_re) rx_rd_r <= rx_mem[rx_ra];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tx_occ_r     <= '0;
      rx_occ_r     <= '0;
      tx_wr_slot_r <= '0;
      tx_rd_slot_r <= '0;
      rx_wr_slot_r <= '0;
      rx_rd_slot_r <= '0;
      rx_cnt_r     <= '0;
      tx_cnt_r     <= '0;
      rx_held_r    <= 1'b0;
      rx_zero_r    <= 1'b1;
      tx_held_r    <= 1'b0;
      rx_asm_r     <= '0;
      tx_cur_r     <= '0;
      drop_r       <= 1'b0;
      drive_r      <= 1'b0;
      load_r       <= 1'b0;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tx_occ_r     <= tx_occ_nxt;
      rx_occ_r     <= rx_occ_nxt;
      tx_wr_slot_r <= tx_wr_slot_nxt;
      tx_rd_slot_r <= tx_rd_slot_nxt;
      rx_wr_slot_r <= rx_wr_slot_nxt;
      rx_rd_slot_r <= rx_rd_slot_nxt;
      rx_cnt_r     <= rx_cnt_nxt;
      tx_cnt_r     <= tx_cnt_nxt;
      rx_held_r    <= rx_held_nxt;
      rx_zero_r    <= rx_zero_nxt;
      tx_held_r    <= tx_held_nxt;
      rx_asm_r     <= rx_asm_nxt;
      tx_cur_r     <= tx_cur_nxt;
      drop_r       <= drop_nxt;
      drive_r      <= drive_nxt;
      load_r       <= load_nxt;
      hit_r        <= hit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: the operation word and the result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode_r    <= in_mode;
      op_err_r     <= in_link_error;
      op_rx_word_r <= in_rx_word;
      op_msg_r     <= in_send_message;
    end
    out_tx_word_r   <= out_tx_word_nxt;
    out_tx_drive_r  <= out_tx_drive_nxt;
    out_msg_valid_r <= out_msg_valid_nxt;
    out_msg_data_r  <= out_msg_data_nxt;
    out_dropped_r   <= out_dropped_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_tx_word   = out_tx_word_r;
  assign out_tx_drive  = out_tx_drive_r;
  assign out_msg_valid = out_msg_valid_r;
  assign out_msg_data  = out_msg_data_r;
  assign out_dropped   = out_dropped_r;

  // Every result follows an accepted word through the exec and fetch states.
  `LMFR_ASSERT_IMP(a_result_follows_accept, out_valid, $past(start && !busy, 3), "result without accepted word")
  // A tick never also returns a polled message.
  `LMFR_ASSERT_IMP(a_tick_not_poll, out_valid && out_tx_drive, !out_msg_valid, "tick result carries a message")
  // A result without a message carries zero data.
  `LMFR_ASSERT_IMP(a_no_msg_zero, out_valid && !out_msg_valid, out_msg_data == '0, "message data without message")
  // A returned message has been removed from the receive ring at the read slot.
  `LMFR_ASSERT_IMP(a_poll_consumes, out_valid && out_msg_valid, !rx_occ_r[rx_rd_slot_r], "polled entry still occupied")
  // The scan cycle always hands over to the capture cycle.
  `LMFR_ASSERT_NXT(a_exec_to_fetch, state_r == S_EXEC, state_r == S_FETCH, "sequencer skipped capture")

endmodule
